@@ rtl/sle_pkg.sv @@
// Shared types and constants of the serial line editor.
`default_nettype none
package sle_pkg;

    localparam int FUNC_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    localparam logic [CHAR_W-1:0] CH_BEL    = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SP     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PROMPT = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_DEL    = 8'h7F;

    typedef enum logic [FUNC_W-1:0] {
        FN_CHAR = 2'd0,
        FN_TICK = 2'd1,
        FN_POLL = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_MODE = 2'd0,
        CFG_ECHO     = 2'd1,
        CFG_MUTE     = 2'd2
    } t_cfg_idx;

    // Kind of result sequence that one input item produces.
    typedef enum logic [2:0] {
        SEQ_NONE,
        SEQ_CHAR,
        SEQ_BELL,
        SEQ_CRLF,
        SEQ_ERASE,
        SEQ_TICK
    } t_seq;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        t_seq seq;
        logic wr_mem;
        logic len_inc;
        logic len_dec;
        logic line_clr;
        logic set_cmpl;
        logic hold_key;
        logic take_key;
        logic emit;
        logic idx_inc;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              is_cr;
        logic              is_erase;
        logic              len_zero;
        logic              len_full;
        logic              cmpl;
        logic              key_mode;
        logic              key_held;
        logic              echo;
        logic              mute;
        logic              slot_free;
        logic              last_item;
    } t_stat;

endpackage
`default_nettype wire

@@ rtl/sle_in_if.sv @@
// Input channel of the serial line editor: function code and received byte.
`default_nettype none
interface sle_in_if import sle_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] rx_char;

    modport source (output valid, output func, output rx_char, input ready);
    modport sink   (input valid, input func, input rx_char, output ready);
endinterface
`default_nettype wire

@@ rtl/sle_out_if.sv @@
// Output channel of the serial line editor: terminal, command and key results.
`default_nettype none
interface sle_out_if import sle_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              term_valid;
    logic [CHAR_W-1:0] term_char;
    logic              cmd_valid;
    logic [CHAR_W-1:0] cmd_byte;
    logic              key_valid;
    logic [CHAR_W-1:0] key_char;
    logic              ready_res;
    logic              last;

    modport source (
        output valid, output term_valid, output term_char, output cmd_valid,
        output cmd_byte, output key_valid, output key_char, output ready_res,
        output last, input ready
    );
    modport sink (
        input valid, input term_valid, input term_char, input cmd_valid,
        input cmd_byte, input key_valid, input key_char, input ready_res,
        input last, output ready
    );
endinterface
`default_nettype wire

@@ rtl/sle_ctrl.sv @@
// Controller state machine: decodes input items and sequences result items.
`default_nettype none
module sle_ctrl import sle_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.seq  = SEQ_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                    case (t_func'(i_stat.func))
                        FN_CHAR: begin
                            if (i_stat.key_mode) begin
                                o_cmd.hold_key = 1'b1;
                            end else if (!i_stat.cmpl) begin
                                if (i_stat.is_cr) begin
                                    o_cmd.set_cmpl = 1'b1;
                                    o_cmd.seq = i_stat.mute ? SEQ_NONE : SEQ_CRLF;
                                end else if (i_stat.is_erase) begin
                                    if (!i_stat.len_zero) begin
                                        o_cmd.len_dec = 1'b1;
                                        o_cmd.seq = i_stat.mute ? SEQ_NONE : SEQ_ERASE;
                                    end
                                end else if (!i_stat.len_full) begin
                                    o_cmd.wr_mem  = 1'b1;
                                    o_cmd.len_inc = 1'b1;
                                    o_cmd.seq = (i_stat.echo && !i_stat.mute) ?
                                                SEQ_CHAR : SEQ_NONE;
                                end else begin
                                    o_cmd.seq = i_stat.mute ? SEQ_NONE : SEQ_BELL;
                                end
                            end
                        end
                        FN_TICK: begin
                            if (!i_stat.key_mode && i_stat.cmpl) begin
                                o_cmd.line_clr = 1'b1;
                                o_cmd.seq      = SEQ_TICK;
                            end
                        end
                        FN_POLL: begin
                            o_cmd.take_key = i_stat.key_held;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_item) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/sle_dp.sv @@
// Datapath: line store, line and key state, configuration and result register.
`default_nettype none
module sle_dp import sle_pkg::*; #(
    parameter int LINE_DEPTH = 64
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire [FUNC_W-1:0]      i_func,
    input  wire [CHAR_W-1:0]      i_rx_char,
    input  wire t_cmd             i_cmd,
    output t_stat                 o_stat,
    sle_out_if.source             o_out
);

    localparam int AW = $clog2(LINE_DEPTH);

    logic [CHAR_W-1:0] mem [LINE_DEPTH];

    logic              r_key_mode;
    logic              r_echo;
    logic              r_mute;
    logic [AW-1:0]     r_len;
    logic              r_cmpl;
    logic              r_key_held;
    logic [CHAR_W-1:0] r_held;
    t_seq              r_seq;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     r_last;
    logic [AW-1:0]     r_nb;
    logic [CHAR_W-1:0] r_char;
    logic              r_key_v;
    logic [CHAR_W-1:0] r_key_c;
    logic [CHAR_W-1:0] r_rd;

    logic              r_out_valid;
    logic              r_term_valid;
    logic [CHAR_W-1:0] r_term_char;
    logic              r_cmd_valid;
    logic [CHAR_W-1:0] r_cmd_byte;
    logic              r_key_valid;
    logic [CHAR_W-1:0] r_key_char;
    logic              r_ready_res;
    logic              r_last_flag;

    logic              n_term_valid;
    logic [CHAR_W-1:0] n_term_char;
    logic              n_cmd_valid;
    logic [CHAR_W-1:0] n_cmd_byte;
    logic              n_key_valid;
    logic [CHAR_W-1:0] n_key_char;
    logic [AW-1:0]     n_cnt;
    logic [AW-1:0]     tick_min;

    // Status toward the controller.
    always_comb begin
        o_stat.func      = i_func;
        o_stat.is_cr     = (i_rx_char == CH_CR);
        o_stat.is_erase  = (i_rx_char == CH_BS) || (i_rx_char == CH_DEL);
        o_stat.len_zero  = (r_len == '0);
        o_stat.len_full  = (r_len == AW'(LINE_DEPTH - 1));
        o_stat.cmpl      = r_cmpl;
        o_stat.key_mode  = r_key_mode;
        o_stat.key_held  = r_key_held;
        o_stat.echo      = r_echo;
        o_stat.mute      = r_mute;
        o_stat.slot_free = !r_out_valid || o_out.ready;
        o_stat.last_item = (r_idx == r_last);
    end

    // Number of result items of the sequence being loaded.
    always_comb begin
        tick_min = r_mute ? AW'(1) : AW'(2);
        case (i_cmd.seq)
            SEQ_CRLF:  n_cnt = AW'(2);
            SEQ_ERASE: n_cnt = AW'(3);
            SEQ_TICK:  n_cnt = (r_len > tick_min) ? r_len : tick_min;
            default:   n_cnt = AW'(1);
        endcase
    end

    // Line store: one write port at the line length, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_mem) begin
            mem[r_len] <= i_rx_char;
        end
        r_rd <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_mode <= 1'b0;
            r_echo     <= 1'b1;
            r_mute     <= 1'b0;
            r_len      <= '0;
            r_cmpl     <= 1'b0;
            r_key_held <= 1'b0;
            r_held     <= '0;
            r_seq      <= SEQ_NONE;
            r_idx      <= '0;
            r_last     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_seq   <= i_cmd.seq;
                r_idx   <= '0;
                r_last  <= n_cnt - AW'(1);
                r_nb    <= r_len;
                r_char  <= i_rx_char;
                r_key_v <= i_cmd.take_key;
                r_key_c <= i_cmd.take_key ? r_held : '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.len_inc) begin
                r_len <= r_len + AW'(1);
            end
            if (i_cmd.len_dec) begin
                r_len <= r_len - AW'(1);
            end
            if (i_cmd.set_cmpl) begin
                r_cmpl <= 1'b1;
            end
            if (i_cmd.line_clr) begin
                r_len  <= '0;
                r_cmpl <= 1'b0;
            end
            if (i_cmd.hold_key) begin
                r_key_held <= 1'b1;
                r_held     <= i_rx_char;
            end
            if (i_cmd.take_key) begin
                r_key_held <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_KEY_MODE: begin
                        r_key_mode <= i_cfg_data[0];
                        if (i_cfg_data[0]) begin
                            r_key_held <= 1'b0;
                        end else begin
                            r_len  <= '0;
                            r_cmpl <= 1'b0;
                        end
                    end
                    CFG_ECHO: r_echo <= i_cfg_data[0];
                    CFG_MUTE: r_mute <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Contents of the result item at the current sequence index.
    always_comb begin
        n_term_valid = 1'b0;
        n_term_char  = '0;
        n_cmd_valid  = 1'b0;
        n_cmd_byte   = '0;
        n_key_valid  = 1'b0;
        n_key_char   = '0;
        case (r_seq)
            SEQ_NONE: begin
                n_key_valid = r_key_v;
                n_key_char  = r_key_c;
            end
            SEQ_CHAR: begin
                n_term_valid = 1'b1;
                n_term_char  = r_char;
            end
            SEQ_BELL: begin
                n_term_valid = 1'b1;
                n_term_char  = CH_BEL;
            end
            SEQ_CRLF: begin
                n_term_valid = 1'b1;
                n_term_char  = (r_idx == '0) ? CH_CR : CH_LF;
            end
            SEQ_ERASE: begin
                n_term_valid = 1'b1;
                n_term_char  = (r_idx == AW'(1)) ? CH_SP : CH_BS;
            end
            SEQ_TICK: begin
                if (!r_mute && (r_idx < AW'(2))) begin
                    n_term_valid = 1'b1;
                    n_term_char  = (r_idx == '0) ? CH_PROMPT : CH_SP;
                end
                if (r_idx < r_nb) begin
                    n_cmd_valid = 1'b1;
                    n_cmd_byte  = r_rd;
                end
            end
            default: begin
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_term_valid <= n_term_valid;
            r_term_char  <= n_term_char;
            r_cmd_valid  <= n_cmd_valid;
            r_cmd_byte   <= n_cmd_byte;
            r_key_valid  <= n_key_valid;
            r_key_char   <= n_key_char;
            r_ready_res  <= r_key_mode || !r_cmpl;
            r_last_flag  <= (r_idx == r_last);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.term_valid = r_term_valid;
    assign o_out.term_char  = r_term_char;
    assign o_out.cmd_valid  = r_cmd_valid;
    assign o_out.cmd_byte   = r_cmd_byte;
    assign o_out.key_valid  = r_key_valid;
    assign o_out.key_char   = r_key_char;
    assign o_out.ready_res  = r_ready_res;
    assign o_out.last       = r_last_flag;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= AW'(LINE_DEPTH - 1))
        else $error("line length beyond buffer capacity");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_last)
        else $error("sequence index ran past the last item");

    a_cmd_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && n_cmd_valid |-> r_seq == SEQ_TICK)
        else $error("command byte outside a line transfer");

    a_key_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && n_key_valid |-> !n_term_valid && !n_cmd_valid && r_last == '0)
        else $error("key delivery mixed with other results");
`endif

endmodule
`default_nettype wire

@@ rtl/serial_line_editor.sv @@
// Top level of the serial line editor: controller and datapath.
//
// Usage: the input channel carries one item per received character, tick or
// key poll (func 0, 1, 2; code 3 is ignored). The output channel carries the
// result items of each input, the final one marked by last. Every input gives
// at least one result item; a tick that releases a completed line gives one
// item per line byte, with the prompt "> " riding on the first two items, so
// a shorter line still gives two items unless output is muted.
// Configuration registers (key mode, echo, mute) are written through the plain
// write port; the user must do so only while the block is idle, as the block
// itself does not enforce it. Results of an input are produced one after
// another: each passes through the registered read port of the line store,
// then into the result register.
// Reset returns to line mode with echo on and output unmuted, an empty line,
// no completed line and no held key. The line store contents are not cleared.
// When the receiver stalls, the result register holds its item and the
// sequencer waits; a new input is accepted only after the last result of the
// previous input has been loaded into the result register.
`default_nettype none
module serial_line_editor import sle_pkg::*; #(
    parameter int LINE_DEPTH = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    sle_in_if.sink               i_in,
    sle_out_if.source            o_out
);

    t_cmd  cmd;
    t_stat stat;

    // Decodes each accepted item and steps through its result sequence.
    sle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Holds the line, the key, the configuration and the result register.
    sle_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_func     (i_in.func),
        .i_rx_char  (i_in.rx_char),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire

@@ tb/serial_line_editor_tb.sv @@
// Self-checking testbench of the serial line editor: directed table, then random phases.
`timescale 1ns / 1ps

module serial_line_editor_tb;
    import sle_pkg::*;

    localparam int LINE_DEPTH    = 64;
    localparam int RANDOM_ITEMS  = 100;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PLAN_LEN      = 32;

    // Function code 3 has no meaning; the block must swallow it quietly.
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    // One result item of the editor, field for field as the output channel carries it.
    typedef struct packed {
        logic              term_valid;
        logic [CHAR_W-1:0] term_char;
        logic              cmd_valid;
        logic [CHAR_W-1:0] cmd_byte;
        logic              key_valid;
        logic [CHAR_W-1:0] key_char;
        logic              ready_res;
        logic              last;
    } t_editor_out;

    // A row of the directed table either writes a register, sends an item whose
    // results come from the predictor, or sends an item whose single result is
    // typed into the row (key flag, key character and ready flag).
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PRED,
        ROW_TYPED
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [1:0]        sel;
        logic [CHAR_W-1:0] val;
        logic              kv;
        logic [CHAR_W-1:0] kc;
        logic              rr;
    } t_plan_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_LONG
    } t_stall;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sle_in_if  in_ch ();
    sle_out_if out_ch ();

    serial_line_editor #(.LINE_DEPTH(LINE_DEPTH)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Shadow copy of the editor state and its settings.
    logic [CHAR_W-1:0] line_buf [LINE_DEPTH];
    int                line_len;
    logic              line_done;
    logic              key_pending;
    logic [CHAR_W-1:0] key_byte;
    logic              key_mode_on;
    logic              echo_on;
    logic              mute_on;

    // Results of the item just accepted, and all results still awaited from the block.
    t_editor_out step_out [$];
    t_editor_out awaited_out [$];

    t_plan_row plan [PLAN_LEN];
    t_stall    stall_mode = STALL_NONE;
    int        cycle_count = 0;
    int        mismatches = 0;
    int        fed_items = 0;
    int        burst_left = 0;
    int        phase = 0;
    int        lines_streamed = 0;
    int        bells_rung = 0;
    int        keys_delivered = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // A terminal character goes out as a result item of its own, unless output is muted.
    function automatic void emit_term(logic [CHAR_W-1:0] c);
        t_editor_out r;
        if (mute_on) return;
        r = '0;
        r.term_valid = 1'b1;
        r.term_char  = c;
        step_out.push_back(r);
    endfunction

    // Works out the result items of one accepted input item and advances the shadow state.
    function automatic void editor_respond(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] c);
        t_editor_out r;
        int n_cmd;
        int n_prompt;
        int n_total;
        logic key_v;
        logic [CHAR_W-1:0] key_c;
        step_out.delete();
        key_v = 1'b0;
        key_c = '0;
        case (f)
            FN_CHAR: begin
                if (key_mode_on) begin
                    key_pending = 1'b1;
                    key_byte    = c;
                end else if (!line_done) begin
                    if (c == CH_CR) begin
                        line_done = 1'b1;
                        emit_term(CH_CR);
                        emit_term(CH_LF);
                    end else if (c == CH_BS || c == CH_DEL) begin
                        // Erasing an empty line does nothing at all.
                        if (line_len > 0) begin
                            line_len--;
                            emit_term(CH_BS);
                            emit_term(CH_SP);
                            emit_term(CH_BS);
                        end
                    end else if (line_len < LINE_DEPTH - 1) begin
                        if (echo_on) emit_term(c);
                        line_buf[line_len] = c;
                        line_len++;
                    end else begin
                        emit_term(CH_BEL);
                        bells_rung++;
                    end
                end
            end
            FN_TICK: begin
                // The line bytes and the prompt leave side by side, at most one of each per item.
                if (!key_mode_on && line_done) begin
                    n_cmd    = line_len;
                    n_prompt = mute_on ? 0 : 2;
                    n_total  = (n_cmd > n_prompt) ? n_cmd : n_prompt;
                    for (int k = 0; k < n_total; k++) begin
                        r = '0;
                        if (k < n_prompt) begin
                            r.term_valid = 1'b1;
                            r.term_char  = (k == 0) ? CH_PROMPT : CH_SP;
                        end
                        if (k < n_cmd) begin
                            r.cmd_valid = 1'b1;
                            r.cmd_byte  = line_buf[k];
                        end
                        step_out.push_back(r);
                    end
                    line_len  = 0;
                    line_done = 1'b0;
                    lines_streamed++;
                end
            end
            FN_POLL: begin
                if (key_pending) begin
                    key_v       = 1'b1;
                    key_c       = key_byte;
                    key_pending = 1'b0;
                    keys_delivered++;
                end
            end
            default: ;
        endcase
        // Every input item yields at least one result item.
        if (step_out.size() == 0) begin
            r = '0;
            r.key_valid = key_v;
            r.key_char  = key_c;
            step_out.push_back(r);
        end
        foreach (step_out[k]) begin
            step_out[k].ready_res = key_mode_on || !line_done;
            step_out[k].last      = (k == step_out.size() - 1);
        end
    endfunction

    function automatic void editor_config(t_cfg_idx idx, logic v);
        case (idx)
            CFG_KEY_MODE: begin
                key_mode_on = v;
                if (!v) begin
                    line_len  = 0;
                    line_done = 1'b0;
                end else begin
                    key_pending = 1'b0;
                end
            end
            CFG_ECHO: echo_on = v;
            CFG_MUTE: mute_on = v;
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Sends one item. The sender works in bursts: at the start of each burst it
    // usually idles for a few cycles, but some bursts follow on with no gap.
    // Once the item is accepted its results are predicted, or the typed result
    // of a directed row is queued in their place.
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c,
                             input bit typed, input t_editor_out typed_out);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid   <= 1'b1;
        in_ch.func    <= f;
        in_ch.rx_char <= c;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        editor_respond(f, c);
        if (typed) begin
            awaited_out.push_back(typed_out);
        end else begin
            foreach (step_out[k]) awaited_out.push_back(step_out[k]);
        end
        if (f != FN_UNUSED) fed_items++;
    endtask

    task automatic feed(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c);
        send_item(f, c, 1'b0, '0);
    endtask

    // Stops sending and waits until every awaited result has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (awaited_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A register takes its value at the edge where the write enable is high.
    task automatic write_reg(input t_cfg_idx idx, input logic v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        editor_config(idx, v);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Types one line, ends it with CR and usually ticks it out. A full line is
    // longer than the buffer, so the last characters ring the bell and the tick
    // streams the largest possible line. Other lines mix erases and noise items
    // into random bytes, and may carry characters after CR that must be dropped.
    task automatic type_line(input bit full_line);
        int len;
        logic [CHAR_W-1:0] c;
        len = full_line ? LINE_DEPTH + 2 : $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
            if (full_line)
                c = 8'($urandom_range(8'h20, 8'h7E));
            else if ($urandom_range(0, 7) == 0)
                c = $urandom_range(0, 1) ? CH_BS : CH_DEL;
            else
                c = 8'($urandom_range(0, 255));
            feed(FN_CHAR, c);
            if (!full_line && $urandom_range(0, 15) == 0)
                feed(2'($urandom_range(1, 3)), 8'($urandom));
        end
        feed(FN_CHAR, CH_CR);
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) feed(FN_CHAR, 8'($urandom));
        // Sometimes the line stays pending, to be cleared by a later tick or a write that leaves key mode.
        if ($urandom_range(0, 5) != 0) feed(FN_TICK, 8'($urandom));
    endtask

    // Receiver: checks each accepted result item against the oldest expectation,
    // and stalls on a pattern picked at random: none, coin toss, periodic or long stalls.
    always @(posedge i_clk) begin : result_check
        t_editor_out want;
        if (cycle_count % 150 == 0) stall_mode <= t_stall'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:     out_ch.ready <= 1'b1;
            STALL_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
            STALL_PERIODIC: out_ch.ready <= (cycle_count[1:0] == 2'b00);
            default:        out_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (awaited_out.size() == 0) begin
                $display("%0t: result item with no expectation, expected none, actual %h",
                         $time, {out_ch.term_valid, out_ch.term_char, out_ch.cmd_valid,
                                 out_ch.cmd_byte, out_ch.key_valid, out_ch.key_char});
                mismatches++;
            end else begin
                want = awaited_out.pop_front();
                check_field("term_valid", want.term_valid, out_ch.term_valid);
                check_field("term_char",  want.term_char,  out_ch.term_char);
                check_field("cmd_valid",  want.cmd_valid,  out_ch.cmd_valid);
                check_field("cmd_byte",   want.cmd_byte,   out_ch.cmd_byte);
                check_field("key_valid",  want.key_valid,  out_ch.key_valid);
                check_field("key_char",   want.key_char,   out_ch.key_char);
                check_field("ready_res",  want.ready_res,  out_ch.ready_res);
                check_field("last",       want.last,       out_ch.last);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, awaited_out.size());
            $display("serial_line_editor_tb NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        t_editor_out typed_out;
        logic km;
        logic echo;
        logic mute;
        int sel;
        int plan_fed;

        in_ch.valid   = 1'b0;
        in_ch.func    = FN_CHAR;
        in_ch.rx_char = '0;
        out_ch.ready  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_KEY_MODE;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;

        // Shadow state after reset: line mode, echo on, not muted, nothing held.
        foreach (line_buf[k]) line_buf[k] = '0;
        line_len    = 0;
        line_done   = 1'b0;
        key_pending = 1'b0;
        key_byte    = '0;
        key_mode_on = 1'b0;
        echo_on     = 1'b1;
        mute_on     = 1'b0;

        // Directed table. The opening rows check the state left by reset; then
        // a line is typed, edited with both erase codes, completed, probed with
        // a dropped character and ticked out. Echo off and mute follow, with an
        // empty completed line under mute. Key mode covers a held key, a tick
        // with no effect, two polls and a key mode write that drops a held key.
        plan = '{
            '{ROW_TYPED, FN_POLL,      8'h00,  1'b0, 8'h00, 1'b1},
            '{ROW_TYPED, FN_TICK,      8'h00,  1'b0, 8'h00, 1'b1},
            '{ROW_TYPED, FN_CHAR,      CH_BS,  1'b0, 8'h00, 1'b1},
            '{ROW_TYPED, FN_UNUSED,    8'hFF,  1'b0, 8'h00, 1'b1},
            '{ROW_PRED,  FN_CHAR,      8'h00,  1'b0, 8'h00, 1'b0},
            '{ROW_PRED,  FN_CHAR,      8'hFF,  1'b0, 8'h00, 1'b0},
            '{ROW_PRED,  FN_CHAR,      8'h41,  1'b0, 8'h00, 1'b0},
            '{ROW_PRED,  FN_CHAR,      CH_DEL, 1'b0, 8'h00, 1'b0},
            '{ROW_PRED,  FN_CHAR,      CH_BS,  1'b0, 8'h00, 1'b0},
            '{ROW_PRED,  FN_CHAR,      CH_CR,  1'b0, 8'h00, 1'b0},
            '{ROW_TYPED, FN_CHAR,      8'h55,  1'b0, 8'h00, 1'b0},
            '{ROW_PRED,  FN_TICK,      8'h00,  1'b0, 8'h00, 1'b0},
            '{ROW_CFG,   CFG_ECHO,     8'h00,  1'b0, 8'h00, 1'b0},
            '{ROW_PRED,  FN_CHAR,      8'h61,  1'b0, 8'h00, 1'b0},
            '{ROW_PRED,  FN_CHAR,      CH_DEL, 1'b0, 8'h00, 1'b0},
            '{ROW_PRED,  FN_CHAR,      8'h62,  1'b0, 8'h00, 1'b0},
            '{ROW_PRED,  FN_CHAR,      CH_CR,  1'b0, 8'h00, 1'b0},
            '{ROW_CFG,   CFG_MUTE,     8'h01,  1'b0, 8'h00, 1'b0},
            '{ROW_PRED,  FN_TICK,      8'hA5,  1'b0, 8'h00, 1'b0},
            '{ROW_TYPED, FN_CHAR,      CH_CR,  1'b0, 8'h00, 1'b0},
            '{ROW_TYPED, FN_TICK,      8'h5A,  1'b0, 8'h00, 1'b1},
            '{ROW_CFG,   CFG_KEY_MODE, 8'h01,  1'b0, 8'h00, 1'b0},
            '{ROW_TYPED, FN_CHAR,      CH_CR,  1'b0, 8'h00, 1'b1},
            '{ROW_TYPED, FN_TICK,      8'h00,  1'b0, 8'h00, 1'b1},
            '{ROW_TYPED, FN_POLL,      8'h00,  1'b1, CH_CR, 1'b1},
            '{ROW_TYPED, FN_POLL,      8'h00,  1'b0, 8'h00, 1'b1},
            '{ROW_PRED,  FN_CHAR,      8'h80,  1'b0, 8'h00, 1'b0},
            '{ROW_CFG,   CFG_KEY_MODE, 8'h01,  1'b0, 8'h00, 1'b0},
            '{ROW_TYPED, FN_POLL,      8'h00,  1'b0, 8'h00, 1'b1},
            '{ROW_CFG,   CFG_KEY_MODE, 8'h00,  1'b0, 8'h00, 1'b0},
            '{ROW_CFG,   CFG_ECHO,     8'h01,  1'b0, 8'h00, 1'b0},
            '{ROW_CFG,   CFG_MUTE,     8'h00,  1'b0, 8'h00, 1'b0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < PLAN_LEN; r++) begin
            if (plan[r].kind == ROW_CFG) begin
                drain();
                write_reg(t_cfg_idx'(plan[r].sel), plan[r].val[0]);
            end else begin
                typed_out           = '0;
                typed_out.key_valid = plan[r].kv;
                typed_out.key_char  = plan[r].kc;
                typed_out.ready_res = plan[r].rr;
                typed_out.last      = 1'b1;
                send_item(plan[r].sel, plan[r].val, plan[r].kind == ROW_TYPED, typed_out);
            end
        end
        plan_fed = fed_items;

        // Random phases. Each phase waits for the block to go quiet, then
        // rewrites all three registers; phase n uses the low three bits of n as
        // key mode, echo and mute, so every combination comes round. The first
        // phase types a line longer than the buffer.
        while (fed_items < plan_fed + RANDOM_ITEMS || phase < 8) begin
            {km, echo, mute} = 3'(phase);
            drain();
            write_reg(CFG_KEY_MODE, km);
            write_reg(CFG_ECHO, echo);
            write_reg(CFG_MUTE, mute);
            if (!km) begin
                if (phase == 0) type_line(1'b1);
                repeat ($urandom_range(1, 2)) type_line(1'b0);
            end else begin
                // Key mode: mostly keystrokes and polls, with the odd tick or unused code.
                repeat ($urandom_range(6, 12)) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 5)
                        feed(FN_CHAR, 8'($urandom));
                    else if (sel < 8)
                        feed(FN_POLL, 8'($urandom));
                    else
                        feed((sel == 8) ? FN_TICK : FN_UNUSED, 8'($urandom));
                end
            end
            phase++;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: the directed table, then %0d phases of random settings.",
                 fed_items, phase);
        $display("Lines streamed %0d, bells rung %0d, keys delivered %0d, mismatches %0d.",
                 lines_streamed, bells_rung, keys_delivered, mismatches);
        if (awaited_out.size() != 0)
            $display("%0d expected result items never arrived.", awaited_out.size());
        if (mismatches == 0 && awaited_out.size() == 0) begin
            $display("serial_line_editor_tb OK");
        end else begin
            $display("serial_line_editor_tb NOT OK");
        end
        $finish;
    end

endmodule
